// File: rtl/core/morse_code_slot_encoder_assert.svh
// Assertion macros for the Morse slot encoder checkers.
`ifndef MORSE_CODE_SLOT_ENCODER_ASSERT_SVH
`define MORSE_CODE_SLOT_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MCSE_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MCSE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mcse_pkg.sv
// Package: Morse pattern table, control word layout and microprogram.
package mcse_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned SLOT_W  = 2;
	localparam int unsigned PAT_W   = 8;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned STEP_W  = 4;

	localparam logic [SLOT_W-1:0] SLOT_SILENT = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_SHORT  = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_LONG   = 2'd3;

	// microprogram step addresses
	localparam logic [STEP_W-1:0] ST_FETCH    = 4'd0;
	localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
	localparam logic [STEP_W-1:0] ST_TONE     = 4'd2;
	localparam logic [STEP_W-1:0] ST_GAP_A    = 4'd3;
	localparam logic [STEP_W-1:0] ST_GAP_B    = 4'd4;
	localparam logic [STEP_W-1:0] ST_GAP_C    = 4'd5;
	localparam logic [STEP_W-1:0] ST_END1     = 4'd6;
	localparam logic [STEP_W-1:0] ST_END2     = 4'd7;
	localparam logic [STEP_W-1:0] ST_END3     = 4'd8;

	// jump conditions
	localparam logic [2:0] COND_NONE  = 3'd0;
	localparam logic [2:0] COND_HIT   = 3'd1;
	localparam logic [2:0] COND_SPACE = 3'd2;
	localparam logic [2:0] COND_DASH  = 3'd3;
	localparam logic [2:0] COND_MORE  = 3'd4;

	// slot code source
	localparam logic SRC_ZERO = 1'b0;
	localparam logic SRC_ELEM = 1'b1;

	typedef struct packed {
		logic              fetch;
		logic              emit;
		logic              src;
		logic              last;
		logic              shift;
		logic [2:0]        cond;
		logic [STEP_W-1:0] jmp;
		logic [STEP_W-1:0] nxt;
	} ctl_t;

	typedef struct packed {
		logic             hit;
		logic             space;
		logic [LEN_W-1:0] len;
		logic [PAT_W-1:0] bits;   // first element at the MSB, 1 = dash
	} pat_t;

	function automatic ctl_t mk_ctl(logic fetch, logic emit, logic src, logic last,
			logic shift, logic [2:0] cond, logic [STEP_W-1:0] jmp,
			logic [STEP_W-1:0] nxt);
		ctl_t c;
		c.fetch = fetch;
		c.emit  = emit;
		c.src   = src;
		c.last  = last;
		c.shift = shift;
		c.cond  = cond;
		c.jmp   = jmp;
		c.nxt   = nxt;
		return c;
	endfunction

	// microprogram ROM: jmp taken when the condition holds, else nxt
	function automatic ctl_t ucode_rom(logic [STEP_W-1:0] step);
		ctl_t c;
		case (step)
			ST_FETCH:    c = mk_ctl(1'b1, 1'b0, SRC_ZERO, 1'b0, 1'b0, COND_HIT,
			                        ST_DISPATCH, ST_FETCH);
			ST_DISPATCH: c = mk_ctl(1'b0, 1'b0, SRC_ZERO, 1'b0, 1'b0, COND_SPACE,
			                        ST_GAP_C, ST_TONE);
			ST_TONE:     c = mk_ctl(1'b0, 1'b1, SRC_ELEM, 1'b0, 1'b1, COND_DASH,
			                        ST_GAP_A, ST_GAP_C);
			ST_GAP_A:    c = mk_ctl(1'b0, 1'b1, SRC_ZERO, 1'b0, 1'b0, COND_NONE,
			                        ST_GAP_B, ST_GAP_B);
			ST_GAP_B:    c = mk_ctl(1'b0, 1'b1, SRC_ZERO, 1'b0, 1'b0, COND_NONE,
			                        ST_GAP_C, ST_GAP_C);
			ST_GAP_C:    c = mk_ctl(1'b0, 1'b1, SRC_ZERO, 1'b0, 1'b0, COND_MORE,
			                        ST_TONE, ST_END1);
			ST_END1:     c = mk_ctl(1'b0, 1'b1, SRC_ZERO, 1'b0, 1'b0, COND_NONE,
			                        ST_END2, ST_END2);
			ST_END2:     c = mk_ctl(1'b0, 1'b1, SRC_ZERO, 1'b0, 1'b0, COND_NONE,
			                        ST_END3, ST_END3);
			ST_END3:     c = mk_ctl(1'b0, 1'b1, SRC_ZERO, 1'b1, 1'b0, COND_NONE,
			                        ST_FETCH, ST_FETCH);
			default:     c = mk_ctl(1'b0, 1'b0, SRC_ZERO, 1'b0, 1'b0, COND_NONE,
			                        ST_FETCH, ST_FETCH);
		endcase
		return c;
	endfunction

	function automatic pat_t mk_pat(logic [LEN_W-1:0] len, logic [PAT_W-1:0] bits);
		pat_t p;
		p.hit   = 1'b1;
		p.space = 1'b0;
		p.len   = len;
		p.bits  = bits;
		return p;
	endfunction

	function automatic pat_t morse_lookup(logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] c;
		pat_t              p;
		c = ch;
		if (ch >= 8'h41 && ch <= 8'h5A)
			c = ch + 8'h20;
		p = '0;
		case (c)
			8'h20, 8'h5F: begin
				p.hit   = 1'b1;
				p.space = 1'b1;
			end
			8'h2D: p = mk_pat(4'd6, 8'b10000100);
			8'h2C: p = mk_pat(4'd6, 8'b11001100);
			8'h2E: p = mk_pat(4'd6, 8'b01010100);
			8'h21: p = mk_pat(4'd7, 8'b10001010);
			8'h3F: p = mk_pat(4'd6, 8'b00110000);
			8'h28: p = mk_pat(4'd6, 8'b10110100);
			8'h29: p = mk_pat(4'd5, 8'b10110000);
			8'h3D: p = mk_pat(4'd5, 8'b10001000);
			8'h40: p = mk_pat(4'd6, 8'b01101000);
			8'h2B: p = mk_pat(4'd5, 8'b01010000);
			8'h2F: p = mk_pat(4'd5, 8'b10010000);
			8'h27: p = mk_pat(4'd6, 8'b01111000);
			8'h3A: p = mk_pat(4'd6, 8'b11100000);
			8'h30: p = mk_pat(4'd5, 8'b11111000);
			8'h31: p = mk_pat(4'd5, 8'b01111000);
			8'h32: p = mk_pat(4'd5, 8'b00111000);
			8'h33: p = mk_pat(4'd5, 8'b00011000);
			8'h34: p = mk_pat(4'd5, 8'b00001000);
			8'h35: p = mk_pat(4'd5, 8'b00000000);
			8'h36: p = mk_pat(4'd5, 8'b10000000);
			8'h37: p = mk_pat(4'd5, 8'b11000000);
			8'h38: p = mk_pat(4'd5, 8'b11100000);
			8'h39: p = mk_pat(4'd5, 8'b11110000);
			8'h08: p = mk_pat(4'd8, 8'b00000000);
			8'h61: p = mk_pat(4'd2, 8'b01000000);
			8'h62: p = mk_pat(4'd4, 8'b10000000);
			8'h63: p = mk_pat(4'd4, 8'b10100000);
			8'h64: p = mk_pat(4'd3, 8'b10000000);
			8'h65: p = mk_pat(4'd1, 8'b00000000);
			8'h66: p = mk_pat(4'd4, 8'b00100000);
			8'h67: p = mk_pat(4'd3, 8'b11000000);
			8'h68: p = mk_pat(4'd4, 8'b00000000);
			8'h69: p = mk_pat(4'd2, 8'b00000000);
			8'h6A: p = mk_pat(4'd4, 8'b01110000);
			8'h6B: p = mk_pat(4'd3, 8'b10100000);
			8'h6C: p = mk_pat(4'd4, 8'b01000000);
			8'h6D: p = mk_pat(4'd2, 8'b11000000);
			8'h6E: p = mk_pat(4'd2, 8'b10000000);
			8'h6F: p = mk_pat(4'd3, 8'b11100000);
			8'h70: p = mk_pat(4'd4, 8'b01100000);
			8'h71: p = mk_pat(4'd4, 8'b11010000);
			8'h72: p = mk_pat(4'd3, 8'b01000000);
			8'h73: p = mk_pat(4'd3, 8'b00000000);
			8'h74: p = mk_pat(4'd1, 8'b10000000);
			8'h75: p = mk_pat(4'd3, 8'b00100000);
			8'h76: p = mk_pat(4'd4, 8'b00010000);
			8'h77: p = mk_pat(4'd3, 8'b01100000);
			8'h78: p = mk_pat(4'd4, 8'b10010000);
			8'h79: p = mk_pat(4'd4, 8'b10110000);
			8'h7A: p = mk_pat(4'd4, 8'b11000000);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/core/morse_code_slot_encoder.sv
// Top level: microcoded Morse slot encoder, one character in, a run of slot codes out.
//
//   channel     signals                               direction
//   character   character_valid/ready, character      in
//   slot        slot_valid/ready, slot_code, last_slot out
//
// A character is taken in the fetch step, then one dispatch step, then one slot per
// cycle while the output register has room, set by the sequencer stepping once per
// slot. Unknown characters are taken in the fetch step and give nothing.
// Reset returns the sequencer to fetch and empties the output register.
// A slot step holds while the output register is full and not taken.
module morse_code_slot_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       character_valid,
	output logic                       character_ready,
	input  logic [mcse_pkg::CHAR_W-1:0] character,
	output logic                       slot_valid,
	input  logic                       slot_ready,
	output logic [mcse_pkg::SLOT_W-1:0] slot_code,
	output logic                       last_slot
);
	import mcse_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [PAT_W-1:0]  elem_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              space_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] slot_code_q;
	logic              last_slot_q;

	ctl_t              ctl;
	pat_t              pat;
	logic              fire;
	logic              cond_true;
	logic              accept;
	logic [SLOT_W-1:0] code_d;

	assign ctl = ucode_rom(step_q);
	assign pat = morse_lookup(character);

	assign character_ready = ctl.fetch;
	assign accept          = character_valid && ctl.fetch;
	// a slot step waits for room in the output register
	assign fire = !ctl.emit || !out_valid_q || slot_ready;

	always_comb begin
		case (ctl.cond)
			COND_NONE:  cond_true = 1'b0;
			COND_HIT:   cond_true = accept && pat.hit;
			COND_SPACE: cond_true = space_q;
			COND_DASH:  cond_true = elem_q[PAT_W-1];
			COND_MORE:  cond_true = (cnt_q != '0);
			default:    cond_true = 1'b0;
		endcase
	end

	assign code_d = (ctl.src == SRC_ELEM) ? (elem_q[PAT_W-1] ? SLOT_LONG : SLOT_SHORT)
	                                      : SLOT_SILENT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_FETCH;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				step_q <= cond_true ? ctl.jmp : ctl.nxt;
			if (fire && ctl.emit)
				out_valid_q <= 1'b1;
			else if (slot_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			elem_q  <= pat.bits;
			cnt_q   <= pat.len;
			space_q <= pat.space;
		end else if (fire && ctl.shift) begin
			elem_q <= {elem_q[PAT_W-2:0], 1'b0};
			cnt_q  <= cnt_q - LEN_W'(1);
		end
		if (fire && ctl.emit) begin
			slot_code_q <= code_d;
			last_slot_q <= ctl.last;
		end
	end

	assign slot_valid = out_valid_q;
	assign slot_code  = slot_code_q;
	assign last_slot  = last_slot_q;

endmodule

// File: rtl/core/mcse_checker.sv
// Checker on the encoder ports, bound to the top level.
`include "morse_code_slot_encoder_assert.svh"

module mcse_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        character_valid,
	input logic                        character_ready,
	input logic [mcse_pkg::CHAR_W-1:0] character,
	input logic                        slot_valid,
	input logic                        slot_ready,
	input logic [mcse_pkg::SLOT_W-1:0] slot_code,
	input logic                        last_slot
);
	import mcse_pkg::*;

	`MCSE_ASSERT_NEXT(a_char_hold, character_valid && !character_ready, character_valid && $stable(character), "waiting character word changed")
	`MCSE_ASSERT_NEXT(a_slot_hold, slot_valid && !slot_ready, slot_valid && $stable(slot_code) && $stable(last_slot), "stalled slot word changed")
	`MCSE_ASSERT_NOW(a_code_legal, slot_valid, slot_code == SLOT_SILENT || slot_code == SLOT_SHORT || slot_code == SLOT_LONG, "illegal slot code")
	`MCSE_ASSERT_NOW(a_busy_mid_run, slot_valid && !last_slot, !character_ready, "new character taken mid run")
	`MCSE_ASSERT_NOW(a_tone_not_last, slot_valid && slot_code != SLOT_SILENT, !last_slot, "run ends on a tone")

endmodule

bind morse_code_slot_encoder mcse_checker u_mcse_checker (.*);

// File: bench/morse_code_slot_encoder_tb.sv
// Testbench for the Morse slot encoder: random and directed characters, slot runs checked.
module morse_code_slot_encoder_tb;
	import mcse_pkg::*;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	typedef struct {
		logic [CHAR_W-1:0] code;
		idle_mode_e        mode;
	} char_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] code;
		logic              last;
	} slot_word_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int RAND_BLOCKS  = 8;
	localparam int BLOCK_CHARS  = 24;

	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              character_valid = 1'b0;
	logic [CHAR_W-1:0] character       = '0;
	logic              slot_ready      = 1'b0;
	logic              character_ready;
	logic              slot_valid;
	logic [SLOT_W-1:0] slot_code;
	logic              last_slot;

	char_word_t        chars_pending[$];
	slot_word_t        slots_due[$];
	slot_word_t        due;
	idle_mode_e        idle_mode = IDLE_NONE;
	logic [CHAR_W-1:0] table_chars[$];

	bit failed        = 1'b0;
	int cycles        = 0;
	int chars_taken   = 0;
	int chars_silent  = 0;
	int slots_checked = 0;

	morse_code_slot_encoder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.character_valid (character_valid),
		.character_ready (character_ready),
		.character       (character),
		.slot_valid      (slot_valid),
		.slot_ready      (slot_ready),
		.slot_code       (slot_code),
		.last_slot       (last_slot)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// dots and dashes of a character, " " for a word gap, empty when not coded
	function automatic string morse_pattern(logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] c;
		c = ch;
		if (ch >= 8'h41 && ch <= 8'h5A)
			c = ch + 8'h20;
		case (c)
			8'h20, 8'h5F: return " ";
			8'h2D: return "-....-";
			8'h2C: return "--..--";
			8'h2E: return ".-.-.-";
			8'h21: return "-...-.-";
			8'h3F: return "..--..";
			8'h28: return "-.--.-";
			8'h29: return "-.--.";
			8'h3D: return "-...-";
			8'h40: return ".--.-.";
			8'h2B: return ".-.-.";
			8'h2F: return "-..-.";
			8'h27: return ".----.";
			8'h3A: return "---...";
			8'h30: return "-----";
			8'h31: return ".----";
			8'h32: return "..---";
			8'h33: return "...--";
			8'h34: return "....-";
			8'h35: return ".....";
			8'h36: return "-....";
			8'h37: return "--...";
			8'h38: return "---..";
			8'h39: return "----.";
			8'h08: return "........";
			8'h61: return ".-";
			8'h62: return "-...";
			8'h63: return "-.-.";
			8'h64: return "-..";
			8'h65: return ".";
			8'h66: return "..-.";
			8'h67: return "--.";
			8'h68: return "....";
			8'h69: return "..";
			8'h6A: return ".---";
			8'h6B: return "-.-";
			8'h6C: return ".-..";
			8'h6D: return "--";
			8'h6E: return "-.";
			8'h6F: return "---";
			8'h70: return ".--.";
			8'h71: return "--.-";
			8'h72: return ".-.";
			8'h73: return "...";
			8'h74: return "-";
			8'h75: return "..-";
			8'h76: return "...-";
			8'h77: return ".--";
			8'h78: return "-..-";
			8'h79: return "-.--";
			8'h7A: return "--..";
			default: return "";
		endcase
	endfunction

	function automatic void push_slots(logic [SLOT_W-1:0] code, int count);
		slot_word_t s;
		s.code = code;
		s.last = 1'b0;
		repeat (count) slots_due.push_back(s);
	endfunction

	// queue the slot run one accepted character should produce
	function automatic void encode_character(logic [CHAR_W-1:0] ch);
		string      p;
		slot_word_t s;
		p = morse_pattern(ch);
		if (p.len() == 0) begin
			chars_silent++;
			return;
		end
		for (int i = 0; i < p.len(); i++) begin
			if (p[i] == ".") begin
				push_slots(SLOT_SHORT, 1);
				push_slots(SLOT_SILENT, 1);
			end else if (p[i] == "-") begin
				push_slots(SLOT_LONG, 1);
				push_slots(SLOT_SILENT, 3);
			end else begin
				push_slots(SLOT_SILENT, 1);
			end
		end
		push_slots(SLOT_SILENT, 2);
		s.code = SLOT_SILENT;
		s.last = 1'b1;
		slots_due.push_back(s);
	endfunction

	function automatic int idle_pct(idle_mode_e m, bit receiver);
		case (m)
			IDLE_SEND: return receiver ? 0 : 52;
			IDLE_RECV: return receiver ? 52 : 0;
			IDLE_BOTH: return 23;
			default:   return 0;
		endcase
	endfunction

	function automatic void queue_char(logic [CHAR_W-1:0] code, idle_mode_e mode);
		char_word_t w;
		w.code = code;
		w.mode = mode;
		chars_pending.push_back(w);
	endfunction

	// character driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (character_valid && character_ready) begin
				encode_character(character);
				chars_taken++;
			end
			if (!character_valid || character_ready) begin
				if (chars_pending.size() != 0 &&
						$urandom_range(99) >= idle_pct(chars_pending[0].mode, 1'b0)) begin
					character       <= chars_pending[0].code;
					idle_mode       <= chars_pending[0].mode;
					character_valid <= 1'b1;
					void'(chars_pending.pop_front());
				end else begin
					character_valid <= 1'b0;
				end
			end
		end
	end

	// slot monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (slot_valid && slot_ready) begin
				slots_checked++;
				if (slots_due.size() == 0) begin
					$error("unexpected word: slot_code %0d last_slot %0b", slot_code, last_slot);
					failed = 1'b1;
				end else begin
					due = slots_due.pop_front();
					if (slot_code !== due.code) begin
						$error("slot_code: expected %0d, actual %0d", due.code, slot_code);
						failed = 1'b1;
					end
					if (last_slot !== due.last) begin
						$error("last_slot: expected %0b, actual %0b", due.last, last_slot);
						failed = 1'b1;
					end
				end
			end
			slot_ready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b1));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles, slots_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [CHAR_W-1:0] directed[$];
		idle_mode_e        mode;

		for (int c = 0; c < 256; c++)
			if (morse_pattern(c[CHAR_W-1:0]).len() != 0)
				table_chars.push_back(c[CHAR_W-1:0]);

		// NUL, all-ones, backspace, both word gaps, case folding, punctuation,
		// longest and shortest runs, and codes outside the table
		directed = '{8'h00, 8'hFF, 8'h08, 8'h20, 8'h5F, 8'h41, 8'h61, 8'h5A, 8'h7A,
			8'h45, 8'h54, 8'h30, 8'h39, 8'h21, 8'h28, 8'h29, 8'h27, 8'h3A,
			8'h2D, 8'h2C, 8'h2E, 8'h80, 8'h7F, 8'h09};
		foreach (directed[i])
			queue_char(directed[i], IDLE_NONE);

		for (int b = 0; b < RAND_BLOCKS; b++) begin
			mode = idle_mode_e'(b % 4);
			for (int i = 0; i < BLOCK_CHARS; i++) begin
				if ($urandom_range(99) < 75)
					queue_char(table_chars[$urandom_range(table_chars.size() - 1)], mode);
				else
					queue_char(CHAR_W'($urandom_range(255)), mode);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (chars_pending.size() != 0 || character_valid)
			@(posedge clk);
		while (slots_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d characters sent (%0d not coded), %0d slot words checked",
			chars_taken, chars_silent, slots_checked);
		$display("idling modes: none, sender, receiver, both");
		if (!failed)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: morse_code_slot_encoder.f
+incdir+rtl/core
rtl/core/mcse_pkg.sv
rtl/core/morse_code_slot_encoder.sv
rtl/core/mcse_checker.sv
bench/morse_code_slot_encoder_tb.sv
